// ===== src/srxl_pkg.sv =====
`default_nettype none

package srxl_pkg;

  // Default sizes of the channel store and the frame buffer.
  localparam int CHANNELS_DEF    = 16;
  localparam int FRAME_BYTES_DEF = 40;

  // Fixed field widths.
  localparam int CMD_W    = 2;
  localparam int BYTE_W   = 8;
  localparam int CHIDX_W  = 4;
  localparam int STATUS_W = 3;
  localparam int WORD_W   = 16;
  localparam int POS_W    = 6;
  localparam int IDLE_W   = 8;
  localparam int CFG_IDX_W = 2;

  // Sync bytes and the frame lengths they announce.
  localparam logic [BYTE_W-1:0] SYNC_12  = 8'hA1;
  localparam logic [BYTE_W-1:0] SYNC_16  = 8'hA2;
  localparam logic [BYTE_W-1:0] SYNC_W16 = 8'hA6;
  localparam logic [POS_W-1:0]  LEN_12   = 6'd27;
  localparam logic [POS_W-1:0]  LEN_16   = 6'd35;
  localparam logic [POS_W-1:0]  LEN_W16  = 6'd40;

  // Frame layout.
  localparam logic [POS_W-1:0] WORD_BASE_RAW = 6'd1;
  localparam logic [POS_W-1:0] WORD_BASE_W16 = 6'd6;
  localparam logic [POS_W-1:0] STAT_BYTE_POS = 6'd4;
  localparam int               FS_FLAG_BIT   = 4;
  localparam logic [CHIDX_W-1:0] LAST_WORD_12 = 4'd11;
  localparam logic [CHIDX_W-1:0] LAST_WORD_16 = 4'd15;

  // Offset applied to signed channel words and the valid result range.
  localparam logic signed [17:0] CH_OFFSET = 18'sd2000;
  localparam logic signed [17:0] CH_MAX    = 18'sd4000;

  // CRC-16 CCITT.
  localparam logic [WORD_W-1:0] CRC_POLY = 16'h1021;

  // Reset values of the configuration registers.
  localparam logic [WORD_W-1:0] INVALID_RST  = 16'd65534;
  localparam logic [WORD_W-1:0] TIMEOUT_RST  = 16'd0;
  localparam logic [IDLE_W-1:0] IDLE_RST     = 8'd5;
  localparam logic [WORD_W-1:0] FAILSAFE_RST = 16'd53;

  typedef enum logic [CMD_W-1:0] {
    CMD_BYTE = 2'd0,
    CMD_TICK = 2'd1,
    CMD_READ = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_NONE    = 3'd0,
    ST_SKIPPED = 3'd1,
    ST_STORED  = 3'd2,
    ST_GOOD    = 3'd3,
    ST_CRC_BAD = 3'd4,
    ST_DROPPED = 3'd5
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INVALID  = 2'd0,
    REG_TIMEOUT  = 2'd1,
    REG_IDLE     = 2'd2,
    REG_FAILSAFE = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_12  = 2'd0,
    KIND_16  = 2'd1,
    KIND_W16 = 2'd2
  } frame_kind_t;

  // One byte through CRC-16 CCITT, MSB first.
  function automatic logic [WORD_W-1:0] crc_feed(input logic [WORD_W-1:0] crc_in,
                                                 input logic [BYTE_W-1:0] b);
    logic [WORD_W-1:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < BYTE_W; i++) begin
      if (c[WORD_W-1]) begin
        c = {c[WORD_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[WORD_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== src/srxl_in_if.sv =====
`default_nettype none

interface srxl_in_if
  import srxl_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [BYTE_W-1:0]  data_byte;
  logic [CHIDX_W-1:0] channel_index;

  modport source (output valid, output cmd, output data_byte, output channel_index,
                  input ready);
  modport sink (input valid, input cmd, input data_byte, input channel_index,
                output ready);
endinterface

`default_nettype wire

// ===== src/srxl_out_if.sv =====
`default_nettype none

interface srxl_out_if
  import srxl_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [WORD_W-1:0]   read_value;
  logic                receiver_active;
  logic                failsafe_applied;

  modport source (output valid, output status, output read_value,
                  output receiver_active, output failsafe_applied, input ready);
  modport sink (input valid, input status, input read_value,
                input receiver_active, input failsafe_applied, output ready);
endinterface

`default_nettype wire

// ===== src/srxl_cfg_if.sv =====
`default_nettype none

interface srxl_cfg_if
  import srxl_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [WORD_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/srxl_frame_receiver_top.sv =====
`default_nettype none

// SRXL servo frame receiver. Each input beat is a received serial byte, a time
// tick or a channel read, and each produces exactly one result beat. Bytes are
// hunted for a sync byte (0xA1, 0xA2 or 0xA6), buffered in a frame memory and
// checked with CRC-16 CCITT; a good frame is unpacked one channel word at a
// time from the frame memory into the channel memory. A byte, tick or read
// passes the execute and finish states before its result enters the output
// register; the input is ready only in idle, so no beat is taken before the
// last one is through. A good frame end adds a frame memory read and then a
// channel memory write per unpacked word (12 words for a 0xA1 frame, 16 for
// 0xA2 and 0xA6). Failsafe fills are done at once through per-channel valid
// bits, so no clearing pass is needed after reset. The result register lets
// the next beat be accepted while a finished result waits. Configuration
// writes are always taken and must only be issued while the block is idle.
module srxl_frame_receiver_top
  import srxl_pkg::*;
#(
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  srxl_in_if.sink    in_if,
  srxl_out_if.source out_if,
  srxl_cfg_if.sink   cfg_if
);

  localparam int CH_AW = $clog2(CHANNELS);
  localparam int FB_AW = $clog2(FRAME_BYTES);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXEC   = 5'b00010,
    S_UNP_RD = 5'b00100,
    S_UNP_WR = 5'b01000,
    S_FIN    = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // Captured input beat.
  cmd_t               cmd_r;
  logic [BYTE_W-1:0]  byte_r;
  logic [CHIDX_W-1:0] chan_r;

  // Configuration registers.
  logic [WORD_W-1:0] inv_val_r;
  logic [WORD_W-1:0] tmo_val_r;
  logic [IDLE_W-1:0] idle_ticks_r;
  logic [WORD_W-1:0] fs_ticks_r;

  // Receiver state.
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [POS_W-1:0]   exp_len_r, exp_len_nxt;
  logic [WORD_W-1:0]  crc_r, crc_nxt;
  logic [IDLE_W-1:0]  idle_r, idle_nxt;
  logic [WORD_W-1:0]  fs_cnt_r, fs_cnt_nxt;
  frame_kind_t        kind_r, kind_nxt;
  logic               fs_flag_r, fs_flag_nxt;
  logic [CHIDX_W-1:0] word_idx_r, word_idx_nxt;
  logic [CHANNELS-1:0] chan_valid_r, chan_valid_nxt;
  logic [WORD_W-1:0]  fill_val_r, fill_val_nxt;

  // Pending result and output register.
  status_t           res_status_r, res_status_nxt;
  logic [WORD_W-1:0] res_read_r, res_read_nxt;
  logic              res_active_r, res_active_nxt;
  logic              res_fs_r, res_fs_nxt;
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r;
  logic [WORD_W-1:0] out_read_r;
  logic              out_active_r;
  logic              out_fs_r;

  // Memories.
  logic [BYTE_W-1:0] fb_mem [FRAME_BYTES];
  logic [BYTE_W-1:0] fb_hi_q, fb_lo_q;
  logic [WORD_W-1:0] ch_mem [CHANNELS];
  logic [WORD_W-1:0] ch_q;

  logic              fb_we;
  logic [FB_AW-1:0]  fb_waddr, fb_raddr_hi, fb_raddr_lo;
  logic              ch_we;
  logic [CH_AW-1:0]  ch_waddr, ch_raddr;
  logic [WORD_W-1:0] ch_wdata;

  logic in_accept, cfg_accept, out_load, fill;

  // Byte and unpack datapath.
  logic              at_start, b_sync, store;
  logic [WORD_W-1:0] crc_new;
  logic [POS_W-1:0]  sync_len, len_eff, pos_inc;
  frame_kind_t       sync_kind;
  logic [IDLE_W-1:0] idle_inc;
  logic [WORD_W-1:0] fs_inc;
  logic [POS_W-1:0]  word_base, hi_addr, lo_addr;
  logic [CHIDX_W-1:0] word_last;
  logic [WORD_W-1:0] word_raw, word_conv;
  logic signed [17:0] off_sum;
  logic              in_range;

  assign in_accept  = in_if.valid & in_if.ready;
  assign cfg_accept = cfg_if.valid & cfg_if.ready;
  assign in_if.ready  = (state_r == S_IDLE);
  assign cfg_if.ready = 1'b1;

  assign out_if.valid            = out_valid_r;
  assign out_if.status           = out_status_r;
  assign out_if.read_value       = out_read_r;
  assign out_if.receiver_active  = out_active_r;
  assign out_if.failsafe_applied = out_fs_r;

  // Sync detection and CRC of the byte being handled.
  assign at_start = (pos_r == '0);
  assign b_sync   = (byte_r == SYNC_12) || (byte_r == SYNC_16) || (byte_r == SYNC_W16);
  assign store    = !at_start || b_sync;
  assign crc_new  = crc_feed(at_start ? '0 : crc_r, byte_r);
  assign pos_inc  = pos_r + POS_W'(1);
  assign len_eff  = at_start ? sync_len : exp_len_r;

  always_comb begin
    if (byte_r == SYNC_12) begin
      sync_len  = LEN_12;
      sync_kind = KIND_12;
    end else if (byte_r == SYNC_16) begin
      sync_len  = LEN_16;
      sync_kind = KIND_16;
    end else begin
      sync_len  = LEN_W16;
      sync_kind = KIND_W16;
    end
  end

  // Saturating tick counters.
  assign idle_inc = (idle_r == '1) ? idle_r : idle_r + IDLE_W'(1);
  assign fs_inc   = (fs_cnt_r == '1) ? fs_cnt_r : fs_cnt_r + WORD_W'(1);

  // Word addresses and conversion during unpack.
  assign word_base = (kind_r == KIND_W16) ? WORD_BASE_W16 : WORD_BASE_RAW;
  assign hi_addr   = word_base + {1'b0, word_idx_r, 1'b0};
  assign lo_addr   = hi_addr + POS_W'(1);
  assign word_last = (kind_r == KIND_12) ? LAST_WORD_12 : LAST_WORD_16;
  assign word_raw  = {fb_hi_q, fb_lo_q};
  assign off_sum   = {{2{word_raw[WORD_W-1]}}, word_raw} + CH_OFFSET;
  assign in_range  = !off_sum[17] && (off_sum <= CH_MAX);
  assign word_conv = in_range ? off_sum[WORD_W-1:0] : inv_val_r;

  assign fb_waddr    = FB_AW'(pos_r);
  assign fb_raddr_hi = FB_AW'(hi_addr);
  assign fb_raddr_lo = FB_AW'(lo_addr);
  assign ch_raddr    = CH_AW'(in_if.channel_index);
  assign ch_waddr    = CH_AW'(word_idx_r);
  assign ch_wdata    = (kind_r == KIND_W16) ? word_conv : word_raw;

  // Frame and channel memories with registered read ports.
  always_ff @(posedge clk) begin
    if (fb_we) begin
      fb_mem[fb_waddr] <= byte_r;
    end
    fb_hi_q <= fb_mem[fb_raddr_hi];
    fb_lo_q <= fb_mem[fb_raddr_lo];
    if (ch_we) begin
      ch_mem[ch_waddr] <= ch_wdata;
    end
    ch_q <= ch_mem[ch_raddr];
  end

  // Sequencer: handle a beat, unpack a good frame, hand the result on.
  always_comb begin
    state_nxt      = state_r;
    pos_nxt        = pos_r;
    exp_len_nxt    = exp_len_r;
    crc_nxt        = crc_r;
    idle_nxt       = idle_r;
    fs_cnt_nxt     = fs_cnt_r;
    kind_nxt       = kind_r;
    fs_flag_nxt    = fs_flag_r;
    word_idx_nxt   = word_idx_r;
    chan_valid_nxt = chan_valid_r;
    fill_val_nxt   = fill_val_r;
    res_status_nxt = res_status_r;
    res_read_nxt   = res_read_r;
    res_active_nxt = res_active_r;
    res_fs_nxt     = res_fs_r;
    fb_we          = 1'b0;
    ch_we          = 1'b0;
    fill           = 1'b0;
    out_load       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        state_nxt      = S_FIN;
        res_status_nxt = ST_NONE;
        res_read_nxt   = '0;
        res_active_nxt = 1'b0;
        res_fs_nxt     = 1'b0;
        unique case (cmd_r)
          CMD_BYTE: begin
            idle_nxt = '0;
            if (at_start) begin
              crc_nxt = '0;
            end
            if (at_start && b_sync) begin
              exp_len_nxt = sync_len;
              kind_nxt    = sync_kind;
            end
            if (!store) begin
              res_status_nxt = ST_SKIPPED;
            end else begin
              fb_we          = 1'b1;
              crc_nxt        = crc_new;
              res_status_nxt = ST_STORED;
              pos_nxt        = pos_inc;
              if (pos_r == STAT_BYTE_POS) begin
                fs_flag_nxt = byte_r[FS_FLAG_BIT];
              end
              // Frame complete: check the remainder.
              if (pos_inc >= len_eff) begin
                pos_nxt = '0;
                if (crc_new == '0) begin
                  res_status_nxt = ST_GOOD;
                  res_active_nxt = 1'b1;
                  word_idx_nxt   = '0;
                  state_nxt      = S_UNP_RD;
                end else begin
                  res_status_nxt = ST_CRC_BAD;
                end
              end
            end
          end
          CMD_TICK: begin
            idle_nxt = idle_inc;
            if (idle_inc >= idle_ticks_r) begin
              if (!at_start) begin
                res_status_nxt = ST_DROPPED;
              end
              pos_nxt = '0;
            end
            fs_cnt_nxt = fs_inc;
            if (fs_inc >= fs_ticks_r) begin
              fill       = 1'b1;
              res_fs_nxt = 1'b1;
            end
          end
          CMD_READ: begin
            res_read_nxt = chan_valid_r[CH_AW'(chan_r)] ? ch_q : fill_val_r;
          end
          default: begin
          end
        endcase
      end

      S_UNP_RD: begin
        state_nxt = S_UNP_WR;
      end

      S_UNP_WR: begin
        ch_we = 1'b1;
        chan_valid_nxt[ch_waddr] = 1'b1;
        if (word_idx_r == word_last) begin
          state_nxt = S_FIN;
          if ((kind_r == KIND_W16) && fs_flag_r) begin
            fill       = 1'b1;
            res_fs_nxt = 1'b1;
          end else begin
            fs_cnt_nxt = '0;
          end
        end else begin
          word_idx_nxt = word_idx_r + CHIDX_W'(1);
          state_nxt    = S_UNP_RD;
        end
      end

      S_FIN: begin
        if (!out_valid_r || out_if.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A failsafe fill overrides every stored channel at once.
    if (fill) begin
      chan_valid_nxt = '0;
      fill_val_nxt   = tmo_val_r;
    end
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pos_r        <= '0;
      exp_len_r    <= '0;
      crc_r        <= '0;
      idle_r       <= '0;
      fs_cnt_r     <= '0;
      kind_r       <= KIND_12;
      fs_flag_r    <= 1'b0;
      word_idx_r   <= '0;
      chan_valid_r <= '0;
      fill_val_r   <= TIMEOUT_RST;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pos_r        <= pos_nxt;
      exp_len_r    <= exp_len_nxt;
      crc_r        <= crc_nxt;
      idle_r       <= idle_nxt;
      fs_cnt_r     <= fs_cnt_nxt;
      kind_r       <= kind_nxt;
      fs_flag_r    <= fs_flag_nxt;
      word_idx_r   <= word_idx_nxt;
      chan_valid_r <= chan_valid_nxt;
      fill_val_r   <= fill_val_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_val_r    <= INVALID_RST;
      tmo_val_r    <= TIMEOUT_RST;
      idle_ticks_r <= IDLE_RST;
      fs_ticks_r   <= FAILSAFE_RST;
    end else if (cfg_accept) begin
      unique case (cfg_reg_t'(cfg_if.index))
        REG_INVALID:  inv_val_r    <= cfg_if.data;
        REG_TIMEOUT:  tmo_val_r    <= cfg_if.data;
        REG_IDLE:     idle_ticks_r <= cfg_if.data[IDLE_W-1:0];
        REG_FAILSAFE: fs_ticks_r   <= cfg_if.data;
        default: begin
        end
      endcase
    end
  end

  // Payload registers: captured beat, pending result and output.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_r  <= cmd_t'(in_if.cmd);
      byte_r <= in_if.data_byte;
      chan_r <= in_if.channel_index;
    end
    res_status_r <= res_status_nxt;
    res_read_r   <= res_read_nxt;
    res_active_r <= res_active_nxt;
    res_fs_r     <= res_fs_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_read_r   <= res_read_r;
      out_active_r <= res_active_r;
      out_fs_r     <= res_fs_r;
    end
  end

endmodule

`default_nettype wire

// ===== dv/srxl_frame_receiver_top_tb.sv =====
`timescale 1ns / 1ps

module srxl_frame_receiver_top_tb;
  import srxl_pkg::*;

  // One result beat as seen on the output channel.
  typedef struct packed {
    status_t           status;
    logic [WORD_W-1:0] read_value;
    logic              receiver_active;
    logic              failsafe_applied;
  } rx_result_t;

  // Tracks the receiver state and the results still owed by the block.
  class frame_result_tracker;
    logic [WORD_W-1:0] invalid_code;
    logic [WORD_W-1:0] timeout_code;
    logic [IDLE_W-1:0] idle_limit;
    logic [WORD_W-1:0] failsafe_limit;
    logic [WORD_W-1:0] chan_store [16];
    logic [BYTE_W-1:0] frame_mem [40];
    int unsigned       fill_pos;
    int unsigned       frame_len;
    int unsigned       idle_cnt;
    int unsigned       lost_cnt;
    logic [WORD_W-1:0] crc;
    rx_result_t        pending_results [$];
    int                mismatches;

    function new();
      invalid_code   = INVALID_RST;
      timeout_code   = TIMEOUT_RST;
      idle_limit     = IDLE_RST;
      failsafe_limit = FAILSAFE_RST;
      fill_channels(TIMEOUT_RST);
      fill_pos   = 0;
      frame_len  = 0;
      idle_cnt   = 0;
      lost_cnt   = 0;
      crc        = '0;
      mismatches = 0;
    endfunction

    // CRC-16 CCITT over one byte, MSB first, no final inversion.
    static function logic [WORD_W-1:0] ccitt_next(logic [WORD_W-1:0] c, logic [BYTE_W-1:0] b);
      logic [WORD_W-1:0] r;
      r = c ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
        r = r[15] ? ({r[14:0], 1'b0} ^ 16'h1021) : {r[14:0], 1'b0};
      end
      return r;
    endfunction

    function void fill_channels(logic [WORD_W-1:0] v);
      foreach (chan_store[i]) chan_store[i] = v;
    endfunction

    function void set_register(cfg_reg_t idx, logic [WORD_W-1:0] v);
      case (idx)
        REG_INVALID:  invalid_code   = v;
        REG_TIMEOUT:  timeout_code   = v;
        REG_IDLE:     idle_limit     = v[IDLE_W-1:0];
        REG_FAILSAFE: failsafe_limit = v;
        default: ;
      endcase
    endfunction

    // Moves the channel words of a finished frame into the store.
    // Returns 1 when the frame carried the failsafe flag.
    function bit unpack_frame();
      logic [WORD_W-1:0] w;
      int                s;
      int                v;
      case (frame_mem[0])
        SYNC_16: begin
          for (int i = 0; i < 16; i++) chan_store[i] = {frame_mem[1+2*i], frame_mem[2+2*i]};
        end
        SYNC_12: begin
          for (int i = 0; i < 12; i++) chan_store[i] = {frame_mem[1+2*i], frame_mem[2+2*i]};
        end
        SYNC_W16: begin
          for (int i = 0; i < 16; i++) begin
            w = {frame_mem[6+2*i], frame_mem[7+2*i]};
            s = $signed(w);
            v = s + 2000;
            chan_store[i] = (v < 0 || v > 4000) ? invalid_code : v[15:0];
          end
          if (frame_mem[4][4]) begin
            fill_channels(timeout_code);
            return 1'b1;
          end
        end
        default: ;
      endcase
      lost_cnt = 0;
      return 1'b0;
    endfunction

    // Works out the result of one accepted input beat.
    function void take_input(cmd_t c, logic [BYTE_W-1:0] b, logic [CHIDX_W-1:0] ch);
      rx_result_t r;
      r = '0;
      r.status = ST_NONE;
      case (c)
        CMD_BYTE: begin
          idle_cnt = 0;
          r.status = ST_STORED;
          if (fill_pos == 0) begin
            crc = '0;
            if (b == SYNC_12) frame_len = LEN_12;
            else if (b == SYNC_16) frame_len = LEN_16;
            else if (b == SYNC_W16) frame_len = LEN_W16;
            else r.status = ST_SKIPPED;
          end
          if (r.status == ST_STORED) begin
            frame_mem[fill_pos % 40] = b;
            fill_pos = (fill_pos + 1) & 63;
            crc = ccitt_next(crc, b);
            if (fill_pos >= frame_len) begin
              if (crc == 0) begin
                r.status = ST_GOOD;
                r.receiver_active = 1'b1;
                r.failsafe_applied = unpack_frame();
              end else begin
                r.status = ST_CRC_BAD;
              end
              fill_pos = 0;
            end
          end
        end
        CMD_TICK: begin
          if (idle_cnt < 255) idle_cnt++;
          if (idle_cnt >= idle_limit) begin
            if (fill_pos != 0) r.status = ST_DROPPED;
            fill_pos = 0;
          end
          if (lost_cnt < 65535) lost_cnt++;
          if (lost_cnt >= failsafe_limit) begin
            fill_channels(timeout_code);
            r.failsafe_applied = 1'b1;
          end
        end
        CMD_READ: r.read_value = chan_store[ch];
        default: ;
      endcase
      pending_results.push_back(r);
    endfunction

    task report(string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Compares one result beat with the oldest expectation.
    task check_result(rx_result_t got);
      rx_result_t want;
      if (pending_results.size() == 0) begin
        report("result beat with nothing expected");
      end else begin
        want = pending_results.pop_front();
        if (got.status != want.status)
          report($sformatf("status field exp %0d got %0d", want.status, got.status));
        if (got.read_value != want.read_value)
          report($sformatf("read_value exp %h got %h", want.read_value, got.read_value));
        if (got.receiver_active != want.receiver_active)
          report($sformatf("receiver_active exp %b got %b", want.receiver_active,
                           got.receiver_active));
        if (got.failsafe_applied != want.failsafe_applied)
          report($sformatf("failsafe_applied exp %b got %b", want.failsafe_applied,
                           got.failsafe_applied));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;

  srxl_in_if  in_if ();
  srxl_out_if out_if ();
  srxl_cfg_if cfg_if ();

  srxl_frame_receiver_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  frame_result_tracker tracker;
  int                  items_sent;
  bit                  in_gaps;
  bit                  out_stalls;
  int                  out_wait;
  rx_result_t          seen_beat;

  // Clock and known values on every input from time zero.
  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.cmd = CMD_NONE;
    in_if.data_byte = '0;
    in_if.channel_index = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_INVALID;
    cfg_if.data = '0;
    out_wait = 0;
    in_gaps = 1'b1;
    out_stalls = 1'b1;
    items_sent = 0;
    tracker = new();
  end

  always #4 clk = ~clk;

  // Result side: after each beat, hold ready low for a drawn number of cycles.
  always @(posedge clk) begin
    if (out_if.valid && out_if.ready) begin
      out_wait = out_stalls ? $urandom_range(0, 4) : 0;
      out_if.ready <= (out_wait == 0);
    end else if (out_wait > 0) begin
      out_wait = out_wait - 1;
      out_if.ready <= (out_wait == 0);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      seen_beat.status = status_t'(out_if.status);
      seen_beat.read_value = out_if.read_value;
      seen_beat.receiver_active = out_if.receiver_active;
      seen_beat.failsafe_applied = out_if.failsafe_applied;
      tracker.check_result(seen_beat);
    end
  end

  // Sends one input beat; called and returning at a rising edge.
  task automatic send_beat(cmd_t c, logic [BYTE_W-1:0] b, logic [CHIDX_W-1:0] ch);
    int gap;
    gap = in_gaps ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.cmd <= c;
    in_if.data_byte <= b;
    in_if.channel_index <= ch;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    tracker.take_input(c, b, ch);
    items_sent++;
  endtask

  task automatic put_byte(logic [BYTE_W-1:0] b);
    send_beat(CMD_BYTE, b, CHIDX_W'($urandom));
  endtask

  task automatic put_tick();
    send_beat(CMD_TICK, BYTE_W'($urandom), CHIDX_W'($urandom));
  endtask

  task automatic put_read(logic [CHIDX_W-1:0] ch);
    send_beat(CMD_READ, BYTE_W'($urandom), ch);
  endtask

  // Holds the input side until every owed result has been taken.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [WORD_W-1:0] v);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= v;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    tracker.set_register(idx, v);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(logic [WORD_W-1:0] inv, logic [WORD_W-1:0] tmo,
                                logic [IDLE_W-1:0] idl, logic [WORD_W-1:0] fsl);
    drain();
    write_reg(REG_INVALID, inv);
    write_reg(REG_TIMEOUT, tmo);
    write_reg(REG_IDLE, idl);
    write_reg(REG_FAILSAFE, fsl);
  endtask

  // Builds a frame with a valid CRC and sends it byte by byte.
  // cut: 0 sends the whole frame, a negative value a random strict prefix.
  // fs_sel: 0 random failsafe flag, 1 flag clear, 2 flag set.
  task automatic send_frame(frame_kind_t kind, int cut, bit corrupt, bit edge_words,
                            int fs_sel);
    logic [BYTE_W-1:0] fb [40];
    logic [WORD_W-1:0] c;
    logic [WORD_W-1:0] w;
    int                len;
    int                wbase;
    int                nwords;
    int                i;
    int                ofs;
    int                gap_pos;
    int                gap_ticks;
    case (kind)
      KIND_12: begin fb[0] = SYNC_12; len = 27; wbase = 1; nwords = 12; end
      KIND_16: begin fb[0] = SYNC_16; len = 35; wbase = 1; nwords = 16; end
      default: begin fb[0] = SYNC_W16; len = 40; wbase = 6; nwords = 16; end
    endcase
    for (i = 1; i < len; i++) fb[i] = BYTE_W'($urandom);

    // Channel words: raw frames take any value, offset frames lean toward the valid range.
    for (i = 0; i < nwords; i++) begin
      if (kind != KIND_W16) begin
        w = edge_words ? ((i % 2) ? 16'hFFFF : 16'h0000) : 16'($urandom);
      end else if (edge_words) begin
        case (i)
          0: w = 16'hF830;
          1: w = 16'h07D0;
          2: w = 16'hF82F;
          3: w = 16'h07D1;
          4: w = 16'h8000;
          5: w = 16'h7FFF;
          6: w = 16'h0000;
          default: w = 16'($urandom);
        endcase
      end else begin
        case ($urandom_range(0, 9))
          7: begin
            case ($urandom_range(0, 3))
              0: w = 16'hF830;
              1: w = 16'h07D0;
              2: w = 16'hF82F;
              default: w = 16'h07D1;
            endcase
          end
          8, 9: w = 16'($urandom);
          default: begin
            ofs = $urandom_range(0, 4000);
            ofs = ofs - 2000;
            w = ofs[15:0];
          end
        endcase
      end
      fb[wbase+2*i] = w[15:8];
      fb[wbase+2*i+1] = w[7:0];
    end

    if (kind == KIND_W16) begin
      if (fs_sel == 1) fb[4][4] = 1'b0;
      else if (fs_sel == 2) fb[4][4] = 1'b1;
      else fb[4][4] = ($urandom_range(0, 7) == 0);
    end

    // Trailing CRC so that the remainder over the whole frame is zero.
    c = '0;
    for (i = 0; i < len - 2; i++) c = frame_result_tracker::ccitt_next(c, fb[i]);
    fb[len-2] = c[15:8];
    fb[len-1] = c[7:0];

    if (corrupt) begin
      i = $urandom_range(1, len - 1);
      fb[i] = fb[i] ^ 8'($urandom_range(1, 255));
    end

    if (cut < 0) cut = $urandom_range(1, len - 1);
    else if (cut == 0) cut = len;

    // Sometimes a few ticks inside the frame, fewer than the idle limit.
    gap_pos = -1;
    gap_ticks = 0;
    if (tracker.idle_limit > 1 && cut > 1 && $urandom_range(0, 3) == 0) begin
      gap_pos = $urandom_range(1, cut - 1);
      gap_ticks = $urandom_range(1, (tracker.idle_limit > 7) ? 6 : tracker.idle_limit - 1);
    end

    for (i = 0; i < cut; i++) begin
      if (i == gap_pos) repeat (gap_ticks) put_tick();
      put_byte(fb[i]);
    end
  endtask

  // Mostly well-formed frames, mixed with ticks, reads, noise and broken frames.
  task automatic random_traffic(int n);
    int                stop;
    int                sel;
    logic [BYTE_W-1:0] b;
    stop = items_sent + n;
    while (items_sent < stop) begin
      if ($urandom_range(0, 15) == 0) begin
        in_gaps = 1'($urandom_range(0, 1));
        out_stalls = 1'($urandom_range(0, 1));
      end
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        send_frame(frame_kind_t'($urandom_range(0, 2)), 0, 1'b0, 1'b0, 0);
      end else if (sel < 63) begin
        send_frame(frame_kind_t'($urandom_range(0, 2)), 0, 1'b1, 1'b0, 0);
      end else if (sel < 69) begin
        send_frame(frame_kind_t'($urandom_range(0, 2)), -1, 1'b0, 1'b0, 0);
        repeat (tracker.idle_limit) put_tick();
      end else if (sel < 79) begin
        repeat ($urandom_range(1, 8)) put_tick();
      end else if (sel < 91) begin
        repeat ($urandom_range(1, 4)) put_read(CHIDX_W'($urandom));
      end else if (sel < 97) begin
        do b = BYTE_W'($urandom); while (b == SYNC_12 || b == SYNC_16 || b == SYNC_W16);
        put_byte(b);
      end else begin
        send_beat(CMD_NONE, BYTE_W'($urandom), CHIDX_W'($urandom));
      end
    end
  endtask

  // Main sequence.
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed cases: unused command, reset channel values and skipped bytes.
    send_beat(CMD_NONE, 8'hFF, 4'hF);
    put_read(4'd0);
    put_read(4'd15);
    put_byte(8'h00);
    put_byte(8'hFF);

    // Good frames of each kind, boundary offsets and the failsafe flag.
    send_frame(KIND_12, 0, 1'b0, 1'b1, 0);
    put_read(4'd11);
    put_read(4'd12);
    send_frame(KIND_16, 0, 1'b0, 1'b1, 0);
    put_read(4'd15);
    send_frame(KIND_W16, 0, 1'b0, 1'b1, 1);
    put_read(4'd0);
    put_read(4'd2);
    send_frame(KIND_W16, 0, 1'b0, 1'b0, 2);
    put_read(4'd5);

    // Bad CRC, a partial frame dropped by idle ticks, and a tick with nothing pending.
    send_frame(KIND_16, 0, 1'b1, 1'b0, 0);
    send_frame(KIND_12, 10, 1'b0, 1'b0, 0);
    repeat (5) put_tick();
    put_tick();

    // Failsafe reached through ticks alone.
    apply_settings(INVALID_RST, 16'hBEEF, IDLE_RST, 16'd3);
    repeat (4) put_tick();
    put_read(4'd7);

    // Random phases over several register settings, extremes included.
    apply_settings(INVALID_RST, TIMEOUT_RST, IDLE_RST, FAILSAFE_RST);
    random_traffic(400);
    apply_settings(16'h0000, 16'hFFFF, 8'd1, 16'd1);
    random_traffic(200);
    apply_settings(16'hFFFF, 16'h0000, 8'd255, 16'hFFFF);
    random_traffic(250);
    apply_settings(16'($urandom), 16'($urandom), 8'($urandom_range(1, 255)),
                   16'($urandom_range(1, 120)));
    random_traffic(350);
    apply_settings(16'($urandom), 16'($urandom), 8'd3, 16'd20);
    random_traffic(250);

    drain();
    repeat (40) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(20_000_000);
    $display("status: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/srxl_pkg.sv
src/srxl_in_if.sv
src/srxl_out_if.sv
src/srxl_cfg_if.sv
src/srxl_frame_receiver_top.sv
dv/srxl_frame_receiver_top_tb.sv
